[rtl/chi2kv_pkg.sv]
// ----------------------------------------------------------------------------
// chi2kv_pkg
// Shared types and constants for the chi-squared kernel value unit.
// ----------------------------------------------------------------------------
package chi2kv_pkg;

    localparam int ELEM_WIDTH_DEF = 16;
    localparam int ACC_WIDTH_DEF  = 48;
    localparam int LAMBDA_W       = 24;
    localparam int KV_W           = 17;
    localparam int FRAC_W         = 16;

    localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 24'd65536;
    localparam logic [30:0]         LOG2E_Q30    = 31'd1549082005;

    // 2^(-2^-i) in Q0.24, i = 1..16
    function automatic logic [23:0] pow2_neg(input logic [3:0] idx);
        logic [23:0] v;
        case (idx)
            4'd0:    v = 24'd11863283;
            4'd1:    v = 24'd14107901;
            4'd2:    v = 24'd15384775;
            4'd3:    v = 24'd16065917;
            4'd4:    v = 24'd16417715;
            4'd5:    v = 24'd16596492;
            4'd6:    v = 24'd16686609;
            4'd7:    v = 24'd16731851;
            4'd8:    v = 24'd16754518;
            4'd9:    v = 24'd16765863;
            4'd10:   v = 24'd16771539;
            4'd11:   v = 24'd16774377;
            4'd12:   v = 24'd16775796;
            4'd13:   v = 24'd16776506;
            4'd14:   v = 24'd16776861;
            default: v = 24'd16777039;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic       load;
        logic       sqr;
        logic       dinit;
        logic       dstep;
        logic       acc;
        logic       mlo;
        logic       mhi;
        logic       arg;
        logic       logm;
        logic       einit;
        logic       estep;
        logic [3:0] eidx;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_status;

endpackage

[rtl/chi2kv_datapath.sv]
// ----------------------------------------------------------------------------
// chi2kv_datapath
// Square, radix-4 divider, accumulator and exp(-x) evaluator.
// ----------------------------------------------------------------------------
module chi2kv_datapath import chi2kv_pkg::*; #(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int ACC_WIDTH  = ACC_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [LAMBDA_W-1:0]   i_cfg_wr_data,
    input  logic [ELEM_WIDTH-1:0] i_elem_a,
    input  logic [ELEM_WIDTH-1:0] i_elem_b,
    input  logic                  i_last_dim,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic [KV_W-1:0]       o_kernel_value,
    output logic                  o_saturated
);

    localparam int E  = ELEM_WIDTH;
    localparam int QW = E + FRAC_W + ((E + FRAC_W) % 2);
    localparam int NW = 2 * E + FRAC_W;
    localparam int WW = (QW > ACC_WIDTH) ? QW : ACC_WIDTH;

    logic [LAMBDA_W-1:0]  r_lambda;
    logic [E-1:0]         r_a, r_b;
    logic                 r_last;
    logic [2*E-1:0]       r_sq;
    logic [E:0]           r_s;
    logic [E:0]           r_rem;
    logic [QW-1:0]        r_dvd, r_q;
    logic [ACC_WIDTH-1:0] r_dist;
    logic                 r_sum_sat;
    logic [55:0]          r_plo, r_phi;
    logic [31:0]          r_arg;
    logic                 r_arg_sat;
    logic [32:0]          r_y;
    logic [15:0]          r_fsh;
    logic [24:0]          r_m;
    logic [KV_W-1:0]      r_kv;
    logic                 r_sat_out;

    logic [E-1:0]         w_diff;
    logic [E:0]           w_sum;
    logic [NW-1:0]        w_n;
    logic [NW-1:0]        w_n_hi;
    logic [E:0]           n_rem;
    logic [QW-1:0]        n_dvd, n_q;
    logic [WW-1:0]        w_qext;
    logic                 w_tsat;
    logic [ACC_WIDTH-1:0] w_term;
    logic [ACC_WIDTH:0]   w_acc;
    logic [63:0]          w_d64;
    logic                 w_phi_big;
    logic [40:0]          w_argsum;
    logic [62:0]          w_lprod;
    logic [48:0]          w_mprod;
    logic [4:0]           w_t;
    logic [25:0]          w_rnd;
    logic [25:0]          w_msum;
    logic [25:0]          w_mshift;
    logic [KV_W-1:0]      w_kv;

    assign w_diff = (r_a > r_b) ? (r_a - r_b) : (r_b - r_a);
    assign w_sum  = (E+1)'(r_a) + (E+1)'(r_b);
    assign w_n    = {r_sq, {FRAC_W{1'b0}}};
    assign w_n_hi = w_n >> QW;

    // two restoring steps per cycle
    always_comb begin
        logic [E+1:0] trial;
        logic [E+1:0] tdiff;
        n_rem = r_rem;
        n_dvd = r_dvd;
        n_q   = r_q;
        for (int j = 0; j < 2; j++) begin
            trial = {n_rem, n_dvd[QW-1]};
            tdiff = trial - {1'b0, r_s};
            if (trial >= {1'b0, r_s}) begin
                n_rem = tdiff[E:0];
            end else begin
                n_rem = trial[E:0];
            end
            n_q   = {n_q[QW-2:0], (trial >= {1'b0, r_s})};
            n_dvd = {n_dvd[QW-2:0], 1'b0};
        end
    end

    assign w_qext = WW'(r_q);
    assign w_tsat = (w_qext >> ACC_WIDTH) != '0;
    assign w_term = w_tsat ? '1 : w_qext[ACC_WIDTH-1:0];
    assign w_acc  = {1'b0, r_dist} + {1'b0, w_term};

    assign w_d64     = 64'(r_dist);
    assign w_phi_big = |r_phi[55:16];
    assign w_argsum  = {9'd0, r_phi[15:0], 16'd0} + {1'b0, r_plo[55:16]};
    assign w_lprod   = 63'(r_arg) * 63'(LOG2E_Q30);
    assign w_mprod   = 49'(r_m) * 49'(pow2_neg(i_cmd.eidx)) + 49'(24'h800000);

    assign w_t      = 5'd8 + r_y[20:16];
    assign w_rnd    = 26'd1 << (w_t - 5'd1);
    assign w_msum   = 26'(r_m) + w_rnd;
    assign w_mshift = w_msum >> w_t;
    assign w_kv     = (r_y[32:16] >= 17'd18) ? '0 : w_mshift[KV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lambda  <= LAMBDA_RESET;
            r_dist    <= '0;
            r_sum_sat <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_lambda <= i_cfg_wr_data;
            end
            if (i_cmd.acc) begin
                if (w_acc[ACC_WIDTH]) begin
                    r_dist    <= '1;
                    r_sum_sat <= 1'b1;
                end else begin
                    r_dist    <= w_acc[ACC_WIDTH-1:0];
                    r_sum_sat <= r_sum_sat | w_tsat;
                end
            end else if (i_cmd.out_load) begin
                r_dist    <= '0;
                r_sum_sat <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a    <= i_elem_a;
            r_b    <= i_elem_b;
            r_last <= i_last_dim;
        end
        if (i_cmd.sqr) begin
            r_sq <= (2*E)'(w_diff) * (2*E)'(w_diff);
            r_s  <= (w_sum == '0) ? (E+1)'(1) : w_sum;
        end
        if (i_cmd.dinit) begin
            r_rem <= w_n_hi[E:0];
            r_dvd <= w_n[QW-1:0];
            r_q   <= '0;
        end
        if (i_cmd.dstep) begin
            r_rem <= n_rem;
            r_dvd <= n_dvd;
            r_q   <= n_q;
        end
        if (i_cmd.mlo) begin
            r_plo <= 56'(r_lambda) * 56'(w_d64[31:0]);
        end
        if (i_cmd.mhi) begin
            r_phi <= 56'(r_lambda) * 56'(w_d64[63:32]);
        end
        if (i_cmd.arg) begin
            if (w_phi_big || (w_argsum[40:32] != '0)) begin
                r_arg     <= '1;
                r_arg_sat <= 1'b1;
            end else begin
                r_arg     <= w_argsum[31:0];
                r_arg_sat <= 1'b0;
            end
        end
        if (i_cmd.logm) begin
            r_y <= w_lprod[62:30];
        end
        if (i_cmd.einit) begin
            r_m   <= 25'h1000000;
            r_fsh <= r_y[15:0];
        end
        if (i_cmd.estep) begin
            if (r_fsh[15]) begin
                r_m <= w_mprod[48:24];
            end
            r_fsh <= {r_fsh[14:0], 1'b0};
        end
        if (i_cmd.out_load) begin
            r_kv      <= w_kv;
            r_sat_out <= r_sum_sat | r_arg_sat;
        end
    end

    assign o_status.last  = r_last;
    assign o_kernel_value = r_kv;
    assign o_saturated    = r_sat_out;

endmodule

[rtl/chi2kv_ctrl.sv]
// ----------------------------------------------------------------------------
// chi2kv_ctrl
// Sequencer for one dimension and the final kernel evaluation.
// ----------------------------------------------------------------------------
module chi2kv_ctrl import chi2kv_pkg::*; #(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int QW        = ELEM_WIDTH + FRAC_W + ((ELEM_WIDTH + FRAC_W) % 2);
    localparam int DIV_STEPS = QW / 2;
    localparam int CW        = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        S_IDLE, S_SQR, S_DINIT, S_DIV, S_ACC, S_MLO, S_MHI,
        S_ARG, S_LOG, S_EINIT, S_EXP, S_OUT
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_cnt;
    logic [3:0]    r_eidx;
    logic          r_out_valid;
    logic          w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.sqr      = (r_state == S_SQR);
        o_cmd.dinit    = (r_state == S_DINIT);
        o_cmd.dstep    = (r_state == S_DIV);
        o_cmd.acc      = (r_state == S_ACC);
        o_cmd.mlo      = (r_state == S_MLO);
        o_cmd.mhi      = (r_state == S_MHI);
        o_cmd.arg      = (r_state == S_ARG);
        o_cmd.logm     = (r_state == S_LOG);
        o_cmd.einit    = (r_state == S_EINIT);
        o_cmd.estep    = (r_state == S_EXP);
        o_cmd.eidx     = r_eidx;
        o_cmd.out_load = (r_state == S_OUT) && w_slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_eidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_SQR;
                    end
                end
                S_SQR:   r_state <= S_DINIT;
                S_DINIT: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(DIV_STEPS - 1)) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC:   r_state <= i_status.last ? S_MLO : S_IDLE;
                S_MLO:   r_state <= S_MHI;
                S_MHI:   r_state <= S_ARG;
                S_ARG:   r_state <= S_LOG;
                S_LOG:   r_state <= S_EINIT;
                S_EINIT: begin
                    r_eidx  <= '0;
                    r_state <= S_EXP;
                end
                S_EXP: begin
                    r_eidx <= r_eidx + 1'b1;
                    if (r_eidx == 4'd15) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken word");

    a_accept_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SQR))
        else $error("accepted word not started");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= CW'(DIV_STEPS - 1)))
        else $error("divider count overrun");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !w_slot_free) |=> (r_state == S_OUT && r_out_valid))
        else $error("stalled result lost");

endmodule

[rtl/chi2_kernel_value_unit.sv]
// ----------------------------------------------------------------------------
// chi2_kernel_value_unit
// Exponential chi-squared kernel: accumulate (a-b)^2/(a+b), emit exp(-l*d).
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  input    in         i_in_valid / o_in_ready    i_elem_a, i_elem_b, i_last_dim
//  result   out        o_out_valid / i_out_ready  o_kernel_value, o_saturated
//  config   in         i_cfg_wr_en                i_cfg_wr_data (lambda, Q8.16)
//
//  A dimension is loaded, squared, divided and accumulated in turn; the
//  divider retires two quotient bits a cycle. The last dimension adds the
//  exponent: the two lambda multiplies, the log2(e) scaling and one table
//  multiply per fraction bit.
//  Reset clears the accumulator, the sticky flag and lambda (to 1.0).
//  A finished word waits in the output register; the next word is taken
//  meanwhile, and only a second result stalls until the first is taken.
// ----------------------------------------------------------------------------
module chi2_kernel_value_unit import chi2kv_pkg::*; #(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int ACC_WIDTH  = ACC_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [LAMBDA_W-1:0]   i_cfg_wr_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ELEM_WIDTH-1:0] i_elem_a,
    input  logic [ELEM_WIDTH-1:0] i_elem_b,
    input  logic                  i_last_dim,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [KV_W-1:0]       o_kernel_value,
    output logic                  o_saturated
);

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer: walks square, divide, accumulate and exponent steps
    chi2kv_ctrl #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // arithmetic: holds the distance sum and the output word
    chi2kv_datapath #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_elem_a       (i_elem_a),
        .i_elem_b       (i_elem_b),
        .i_last_dim     (i_last_dim),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_kernel_value (o_kernel_value),
        .o_saturated    (o_saturated)
    );

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for chi2_kernel_value_unit. Vector pairs are streamed one
// dimension per word, and a bit-exact predictor mirrors the distance
// accumulator and the exp(-lambda*d) evaluation. Each kernel word the block
// emits is checked field by field against a queue of predicted words. The
// stimulus runs under several sender and receiver stall profiles and several
// lambda settings.
// ----------------------------------------------------------------------------
module tb_top;
    import chi2kv_pkg::*;

    localparam int  DRAIN_CYCLES = 80;       // one dimension plus the exponent, with margin
    localparam int  CYCLE_LIMIT  = 600000;
    localparam logic [47:0] ACC_FULL = 48'hFFFF_FFFF_FFFF;
    localparam logic [63:0] ARG_FULL = 64'hFFFF_FFFF;
    localparam logic [63:0] LOG2E    = 64'd1549082005;

    // 2^(-2^-i) in Q0.24, i = 1..16
    localparam logic [23:0] EXP_STEP [16] = '{
        24'd11863283, 24'd14107901, 24'd15384775, 24'd16065917,
        24'd16417715, 24'd16596492, 24'd16686609, 24'd16731851,
        24'd16754518, 24'd16765863, 24'd16771539, 24'd16774377,
        24'd16775796, 24'd16776506, 24'd16776861, 24'd16777039
    };

    typedef struct {
        logic [KV_W-1:0] kv;
        logic            sat;
    } kernel_word_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [LAMBDA_W-1:0] i_cfg_wr_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [15:0]         i_elem_a;
    logic [15:0]         i_elem_b;
    logic                i_last_dim;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [KV_W-1:0]     o_kernel_value;
    logic                o_saturated;

    // Predictor state: a copy of the block's accumulator and register.
    logic [47:0]         dist_acc;
    bit                  dist_sticky;
    logic [LAMBDA_W-1:0] lambda_q;

    kernel_word_t        kernel_expected[$];
    int                  mismatches;
    int                  cycles = 0;
    int                  gap_pct;
    int                  stall_pct;

    chi2_kernel_value_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_elem_a       (i_elem_a),
        .i_elem_b       (i_elem_b),
        .i_last_dim     (i_last_dim),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kernel_value (o_kernel_value),
        .o_saturated    (o_saturated)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: stall at the rate of the current phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0d] %s: got %0d, expected %0d", cycles, what, got, want);
        mismatches++;
    endtask

    // Check each kernel word taken from the block against the oldest prediction.
    always @(posedge i_clk) begin
        kernel_word_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (kernel_expected.size() == 0) begin
                report_mismatch("unexpected kernel word", o_kernel_value, -1);
            end else begin
                want = kernel_expected.pop_front();
                if (o_kernel_value !== want.kv)
                    report_mismatch("kernel_value", o_kernel_value, want.kv);
                if (o_saturated !== want.sat)
                    report_mismatch("saturated", o_saturated, want.sat);
            end
        end
    end

    // (a-b)^2/(a+b) with 16 fraction bits; divisor 1 on a zero sum.
    function automatic logic [47:0] chi_term(input logic [15:0] a, input logic [15:0] b,
                                             output bit ovf);
        logic [63:0] diff, sq, s, qi, rm, fr;
        diff = (a > b) ? 64'(a - b) : 64'(b - a);
        sq   = diff * diff;
        s    = 64'(a) + 64'(b);
        if (s == 0) s = 1;
        qi   = sq / s;
        rm   = sq % s;
        fr   = (rm << 16) / s;
        ovf  = (qi > 64'(ACC_FULL >> 16));
        return ovf ? ACC_FULL : 48'((qi << 16) | fr);
    endfunction

    // exp(-lambda*d) in Q1.16 through base-2 range reduction.
    function automatic logic [KV_W-1:0] kernel_of(input logic [47:0] d, output bit argsat);
        logic [63:0] p_lo, p_hi, arg, y, k, f, m, t;
        p_lo   = 64'(lambda_q) * 64'(d[31:0]);
        p_hi   = 64'(lambda_q) * 64'(d[47:32]);
        argsat = 1'b0;
        if (p_hi >= 64'd65536) begin
            arg    = ARG_FULL;
            argsat = 1'b1;
        end else begin
            arg = (p_hi << 16) + (p_lo >> 16);
            if (arg > ARG_FULL) begin
                arg    = ARG_FULL;
                argsat = 1'b1;
            end
        end
        y = (arg * LOG2E) >> 30;
        k = y >> 16;
        f = y & 64'hFFFF;
        m = 64'd1 << 24;
        for (int i = 0; i < 16; i++) begin
            if (f[15-i])
                m = (m * 64'(EXP_STEP[i]) + (64'd1 << 23)) >> 24;
        end
        t = 64'd8 + k;
        if (t >= 64'd63)
            return '0;
        return KV_W'((m + (64'd1 << (t - 1))) >> t);
    endfunction

    // Fold one accepted dimension into the predictor; queue a word on the last.
    task automatic predict_dim(input logic [15:0] a, input logic [15:0] b, input logic last);
        bit ovf, argsat;
        logic [47:0] term;
        kernel_word_t w;
        term = chi_term(a, b, ovf);
        if (ovf) dist_sticky = 1'b1;
        if (term > ACC_FULL - dist_acc) begin
            dist_acc    = ACC_FULL;
            dist_sticky = 1'b1;
        end else begin
            dist_acc = dist_acc + term;
        end
        if (last) begin
            w.kv  = kernel_of(dist_acc, argsat);
            w.sat = dist_sticky | argsat;
            kernel_expected.push_back(w);
            dist_acc    = '0;
            dist_sticky = 1'b0;
        end
    endtask

    // Send one dimension word. Valid is left high after acceptance so a
    // back-to-back word never sees it dropped and raised in one step.
    task automatic send_dim(input logic [15:0] a, input logic [15:0] b, input logic last);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_elem_a   <= a;
        i_elem_b   <= b;
        i_last_dim <= last;
        do @(posedge i_clk); while (!o_in_ready);
        predict_dim(a, b, last);
    endtask

    // Hold off until every predicted word has come and the block is idle.
    task automatic drain;
        i_in_valid <= 1'b0;
        while (kernel_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_lambda(input logic [LAMBDA_W-1:0] v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        lambda_q = v;
    endtask

    function automatic logic [15:0] pick_elem(input logic [15:0] near);
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            default: return near + 16'($urandom_range(0, 40)) - 16'd20;
        endcase
    endfunction

    task automatic test_directed;
        // Reset lambda of 1.0: zero sum, extremes, tiny and multi-dimension vectors.
        send_dim(16'd0, 16'd0, 1'b1);
        send_dim(16'hFFFF, 16'd0, 1'b1);
        send_dim(16'd0, 16'hFFFF, 1'b1);
        send_dim(16'hFFFF, 16'hFFFF, 1'b1);
        send_dim(16'd1, 16'd0, 1'b1);
        send_dim(16'd100, 16'd101, 1'b1);
        send_dim(16'd500, 16'd497, 1'b0);
        send_dim(16'd0, 16'd0, 1'b0);
        send_dim(16'd20, 16'd22, 1'b1);
        // Lambda zero: every kernel is 1.0.
        set_lambda(24'd0);
        send_dim(16'hFFFF, 16'd0, 1'b1);
        send_dim(16'd7, 16'd9, 1'b1);
        // Largest lambda: the exponent argument clamps.
        set_lambda(24'hFFFFFF);
        send_dim(16'hFFFF, 16'd0, 1'b0);
        send_dim(16'hFFFF, 16'd0, 1'b1);
        send_dim(16'd1, 16'd0, 1'b1);
        send_dim(16'd0, 16'd0, 1'b1);
        // Small lambda keeps the result away from zero.
        set_lambda(24'd3);
        send_dim(16'd40000, 16'd30000, 1'b1);
        send_dim(16'hFFFF, 16'd0, 1'b1);
    endtask

    // Random vector pairs, mostly close features so kernel values stay varied.
    task automatic test_random_vectors(input int n_items);
        int sent, dims;
        logic [15:0] base, a, b;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(4))
                    0:       set_lambda(24'($urandom));
                    1:       set_lambda(24'hFFFFFF);
                    2:       set_lambda(24'($urandom_range(0, 16)));
                    default: set_lambda(24'($urandom_range(0, 70000)));
                endcase
            end
            repeat (8) begin
                dims = $urandom_range(1, 8);
                base = 16'($urandom);
                for (int d = 0; d < dims; d++) begin
                    a = pick_elem(base);
                    b = pick_elem(base);
                    send_dim(a, b, d == dims - 1);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_elem_a      = '0;
        i_elem_b      = '0;
        i_last_dim    = 1'b0;
        mismatches    = 0;
        gap_pct       = 0;
        stall_pct     = 0;
        dist_acc      = '0;
        dist_sticky   = 1'b0;
        lambda_q      = LAMBDA_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();

        // Idle profiles: none, sender gaps, receiver stalls, both.
        gap_pct = 0;  stall_pct = 0;  test_random_vectors(340);
        gap_pct = 82; stall_pct = 0;  test_random_vectors(340);
        gap_pct = 0;  stall_pct = 82; test_random_vectors(340);
        gap_pct = 19; stall_pct = 19; test_random_vectors(340);

        drain();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
